// ===== hw/rtl/mcr_pkg.sv =====
// ---------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants for the midpoint circle rasterizer.
// ---------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

    localparam int COORD_W    = 14;
    localparam int DEC_W      = 12;
    localparam int LANES      = 8;
    localparam int ADDR_W     = 20;
    localparam int SIZE_W     = 11;
    localparam int RESULT_CAP = 48;
    localparam int CNT_W      = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;

    localparam logic signed [DEC_W-1:0] D_INIT = 12'sd3;
    localparam logic signed [DEC_W-1:0] D_DIAG = 12'sd10;
    localparam logic signed [DEC_W-1:0] D_AXIS = 12'sd6;
    localparam logic [SIZE_W-1:0]       CANVAS_RESET = 11'd800;

    typedef enum logic [0:0] {
        WALK_IDLE,
        WALK_RUN
    } walk_state_t;

    typedef struct packed {
        logic signed [11:0] cx;
        logic signed [11:0] cy;
        logic [6:0]         x;
        logic signed [7:0]  y;
        logic [7:0]         color;
        logic               last;
    } step_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mcr_walker.sv =====
// ---------------------------------------------------------------------------
// mcr_walker
// Front end: takes a circle request and walks one octant, one step per
// transfer into the step queue.
// ---------------------------------------------------------------------------
`default_nettype none

module mcr_walker
    import mcr_pkg::*;
#(
    parameter int MAX_RADIUS = 63
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [11:0] center_x,
    input  wire logic signed [11:0] center_y,
    input  wire logic [5:0]         radius,
    input  wire logic [7:0]         color,
    output step_t                   step,
    output logic                    step_valid,
    input  wire logic               step_full
);

    localparam logic [7:0]       RadMax = 8'(MAX_RADIUS);
    localparam logic [CNT_W-1:0] CapIdx = CNT_W'(RESULT_CAP - 1);

    walk_state_t state_reg, state_next;

    logic signed [11:0]      cx_reg, cy_reg;
    logic [7:0]              color_reg;
    logic [6:0]              x_reg, x_next;
    logic signed [7:0]       y_reg, y_next;
    logic signed [DEC_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0]        n_reg, n_next;

    logic              accept, push, more, last;
    logic [7:0]        r_ext, r_eff;
    logic signed [DEC_W-1:0] xs, ys;

    assign accept = in_valid && !in_stall;
    assign push   = step_valid && !step_full;
    assign more   = y_reg >= $signed({1'b0, x_reg});
    assign last   = !more || (n_reg == CapIdx);

    assign r_ext = {2'b00, radius};
    assign r_eff = (r_ext > RadMax) ? RadMax : r_ext;
    assign xs    = $signed({5'b0, x_reg});
    assign ys    = {{(DEC_W-8){y_reg[7]}}, y_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            WALK_IDLE:
            begin
                if (accept)
                begin
                    state_next = WALK_RUN;
                end
            end
            WALK_RUN:
            begin
                if (push && last)
                begin
                    state_next = WALK_IDLE;
                end
            end
            default: state_next = WALK_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            WALK_IDLE:
            begin
                in_stall   = 1'b0;
                step_valid = 1'b0;
            end
            WALK_RUN:
            begin
                in_stall   = 1'b1;
                step_valid = 1'b1;
            end
            default:
            begin
                in_stall   = 1'b1;
                step_valid = 1'b0;
            end
        endcase
    end

    assign step.cx    = cx_reg;
    assign step.cy    = cy_reg;
    assign step.x     = x_reg;
    assign step.y     = y_reg;
    assign step.color = color_reg;
    assign step.last  = last;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        d_next = d_reg;
        n_next = n_reg;
        if (accept)
        begin
            x_next = 7'd0;
            y_next = $signed({1'b0, r_eff[6:0]});
            d_next = D_INIT - $signed({3'b0, r_eff, 1'b0});
            n_next = '0;
        end
        else if (push && !last)
        begin
            x_next = x_reg + 7'd1;
            n_next = n_reg + CNT_W'(1);
            if (d_reg > 0)
            begin
                y_next = y_reg - 8'sd1;
                d_next = d_reg + ((xs - ys + 12'sd2) <<< 2) + D_DIAG;
            end
            else
            begin
                d_next = d_reg + ((xs + 12'sd1) <<< 2) + D_AXIS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= WALK_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            d_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            d_reg     <= d_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg    <= center_x;
            cy_reg    <= center_y;
            color_reg <= color;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mcr_step_fifo.sv =====
// ---------------------------------------------------------------------------
// mcr_step_fifo
// Short queue of octant steps between the walker and the address unit.
// ---------------------------------------------------------------------------
`default_nettype none

module mcr_step_fifo
    import mcr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire step_t push_data,
    input  wire logic  push_valid,
    output logic       full,
    output step_t      head,
    output logic       head_valid,
    input  wire logic  pop
);

    step_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]    count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == (PTR_W+1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mcr_addr_unit.sv =====
// ---------------------------------------------------------------------------
// mcr_addr_unit
// Back end: mirrors one step into eight pixels, clips them to the canvas
// and forms addresses x * size + y. Two stages: clip, then multiply-add.
// ---------------------------------------------------------------------------
`default_nettype none

module mcr_addr_unit
    import mcr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SIZE_W-1:0] size,
    input  wire step_t             head,
    input  wire logic              head_valid,
    output logic                   pop,
    output logic [ADDR_W-1:0]      addr [LANES],
    output logic [LANES-1:0]       mask,
    output logic [7:0]             pixel_color,
    output logic                   last_step,
    output logic                   out_valid,
    input  wire logic              out_stall
);

    logic signed [COORD_W-1:0] cxe, cye, xe, ye;
    logic signed [COORD_W-1:0] a [LANES];
    logic signed [COORD_W-1:0] b [LANES];
    logic [LANES-1:0]          in_canvas;

    logic [SIZE_W-1:0] s1_a_reg [LANES];
    logic [SIZE_W-1:0] s1_b_reg [LANES];
    logic [LANES-1:0]  s1_in_reg;
    logic [7:0]        s1_color_reg;
    logic              s1_last_reg;
    logic              s1_valid_reg;

    logic [ADDR_W-1:0] out_addr_reg [LANES];
    logic [ADDR_W-1:0] out_addr_next [LANES];
    logic [LANES-1:0]  out_mask_reg;
    logic [7:0]        out_color_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    logic s2_ready, s1_ready;
    logic [2*SIZE_W-1:0] sum [LANES];

    assign s2_ready = !out_valid_reg || !out_stall;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign pop      = head_valid && s1_ready;

    assign cxe = {{(COORD_W-12){head.cx[11]}}, head.cx};
    assign cye = {{(COORD_W-12){head.cy[11]}}, head.cy};
    assign xe  = $signed({{(COORD_W-7){1'b0}}, head.x});
    assign ye  = {{(COORD_W-8){head.y[7]}}, head.y};

    always_comb
    begin
        a[0] = cxe + xe;  b[0] = cye + ye;
        a[1] = cxe - xe;  b[1] = cye + ye;
        a[2] = cxe + xe;  b[2] = cye - ye;
        a[3] = cxe - xe;  b[3] = cye - ye;
        a[4] = cxe + ye;  b[4] = cye + xe;
        a[5] = cxe - ye;  b[5] = cye + xe;
        a[6] = cxe + ye;  b[6] = cye - xe;
        a[7] = cxe - ye;  b[7] = cye - xe;
        for (int k = 0; k < LANES; k++)
        begin
            in_canvas[k] = !a[k][COORD_W-1] && !b[k][COORD_W-1]
                        && (a[k][COORD_W-2:0] < {2'b00, size})
                        && (b[k][COORD_W-2:0] < {2'b00, size});
        end
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            sum[k] = ({{SIZE_W{1'b0}}, s1_a_reg[k]} * {{SIZE_W{1'b0}}, size})
                   + {{SIZE_W{1'b0}}, s1_b_reg[k]};
            out_addr_next[k] = s1_in_reg[k] ? sum[k][ADDR_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= head_valid;
            end
            if (s2_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                s1_a_reg[k] <= a[k][SIZE_W-1:0];
                s1_b_reg[k] <= b[k][SIZE_W-1:0];
            end
            s1_in_reg    <= in_canvas;
            s1_color_reg <= head.color;
            s1_last_reg  <= head.last;
        end
        if (s2_ready && s1_valid_reg)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                out_addr_reg[k] <= out_addr_next[k];
            end
            out_mask_reg  <= s1_in_reg;
            out_color_reg <= s1_color_reg;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign addr        = out_addr_reg;
    assign mask        = out_mask_reg;
    assign pixel_color = out_color_reg;
    assign last_step   = out_last_reg;
    assign out_valid   = out_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/midpoint_circle_raster.sv =====
// ---------------------------------------------------------------------------
// midpoint_circle_raster
// Midpoint circle rasterizer: one request in, one result per octant step.
// ---------------------------------------------------------------------------
// A circle request is taken when the walker is idle. The walker produces one
// octant step per cycle into a four-entry queue while the queue is not full;
// the address unit turns each step into eight clipped addresses x * size + y
// through a clip register and a multiply-add register. A circle of radius r
// gives about 0.71*r + 2 results (at most 48), and the next request can be
// taken in the cycle after the walker has queued the last step. canvas_size
// must be written only while no circle is in flight; the block itself does
// not enforce this. Values above MAX_CANVAS clip to MAX_CANVAS.
`default_nettype none

module midpoint_circle_raster
    import mcr_pkg::*;
#(
    parameter int MAX_RADIUS = 63,
    parameter int MAX_CANVAS = 1024
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [10:0]        canvas_size,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [11:0] center_x,
    input  wire logic signed [11:0] center_y,
    input  wire logic [5:0]         radius,
    input  wire logic [7:0]         color,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [19:0]             addr_px_py,
    output logic [19:0]             addr_nx_py,
    output logic [19:0]             addr_px_ny,
    output logic [19:0]             addr_nx_ny,
    output logic [19:0]             addr_py_px,
    output logic [19:0]             addr_ny_px,
    output logic [19:0]             addr_py_nx,
    output logic [19:0]             addr_ny_nx,
    output logic [7:0]              inside_mask,
    output logic [7:0]              pixel_color,
    output logic                    last_step
);

    localparam int          SizeCapInt = (MAX_CANVAS > 2047) ? 2047 : MAX_CANVAS;
    localparam logic [SIZE_W-1:0] SizeCap = SIZE_W'(SizeCapInt);

    logic [SIZE_W-1:0] canvas_size_reg;
    logic [SIZE_W-1:0] size_eff;

    step_t             walk_step, head;
    logic              walk_valid, fifo_full, head_valid, pop;
    logic [ADDR_W-1:0] addr [LANES];

    assign cfg_ready = 1'b1;
    assign size_eff  = (canvas_size_reg > SizeCap) ? SizeCap : canvas_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_size_reg <= CANVAS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            canvas_size_reg <= canvas_size;
        end
    end

    mcr_walker #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .color      (color),
        .step       (walk_step),
        .step_valid (walk_valid),
        .step_full  (fifo_full)
    );

    mcr_step_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (walk_step),
        .push_valid (walk_valid),
        .full       (fifo_full),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    mcr_addr_unit u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .size        (size_eff),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .addr        (addr),
        .mask        (inside_mask),
        .pixel_color (pixel_color),
        .last_step   (last_step),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

    assign addr_px_py = addr[0];
    assign addr_nx_py = addr[1];
    assign addr_px_ny = addr[2];
    assign addr_nx_ny = addr[3];
    assign addr_py_px = addr[4];
    assign addr_ny_px = addr[5];
    assign addr_py_nx = addr[6];
    assign addr_ny_nx = addr[7];

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for midpoint_circle_raster. Circle requests go in
// through a valid/stall channel in random bursts while the result side
// stalls on its own random pattern. A scoreboard walks each accepted circle's
// octant, builds the eight clipped addresses per step and checks every
// result transfer in order. The canvas size is rewritten between phases,
// including zero, one, the maximum and a value that saturates.
// ---------------------------------------------------------------------------

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mcr_pkg::*;

    localparam int CANVAS_MAX    = 1024;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_ITEMS   = 57;

    typedef struct {
        logic signed [11:0] cx;
        logic signed [11:0] cy;
        logic [5:0]         r;
        logic [7:0]         col;
    } circle_t;

    typedef struct packed {
        logic [7:0][19:0] addr;
        logic [7:0]       mask;
        logic [7:0]       col;
        logic             last;
    } pixel_step_t;

    class circle_scoreboard;
        pixel_step_t   pending_steps[$];
        logic [10:0]   canvas;
        int            errors;
        string         lane_names[8];

        function new();
            canvas = CANVAS_RESET;
            errors = 0;
            lane_names = '{"addr_px_py", "addr_nx_py", "addr_px_ny", "addr_nx_ny",
                           "addr_py_px", "addr_ny_px", "addr_py_nx", "addr_ny_nx"};
        endfunction

        function void set_canvas(logic [10:0] v);
            canvas = v;
        endfunction

        function int visible_size();
            return (int'(canvas) > CANVAS_MAX) ? CANVAS_MAX : int'(canvas);
        endfunction

        // Walks one octant and queues every step this circle produces.
        function void note_circle(circle_t c);
            int          x;
            int          y;
            int          d;
            int          n;
            int          cx;
            int          cy;
            int          size;
            int          px[8];
            int          py[8];
            bit          last;
            pixel_step_t s;
            cx = int'(c.cx);
            cy = int'(c.cy);
            size = visible_size();
            x = 0;
            y = int'(c.r);
            d = 3 - 2 * y;
            n = 0;
            forever
            begin
                last = (y < x) || (n + 1 >= RESULT_CAP);
                px = '{cx + x, cx - x, cx + x, cx - x, cx + y, cx - y, cx + y, cx - y};
                py = '{cy + y, cy + y, cy - y, cy - y, cy + x, cy + x, cy - x, cy - x};
                s.mask = '0;
                for (int k = 0; k < 8; k++)
                begin
                    if (px[k] >= 0 && py[k] >= 0 && px[k] < size && py[k] < size)
                    begin
                        s.addr[k] = 20'(px[k] * size + py[k]);
                        s.mask[k] = 1'b1;
                    end
                    else
                    begin
                        s.addr[k] = '0;
                    end
                end
                s.col = c.col;
                s.last = last;
                pending_steps = {pending_steps, s};
                n++;
                if (last)
                    break;
                x++;
                if (d > 0)
                begin
                    y--;
                    d += 4 * (x - y) + 10;
                end
                else
                begin
                    d += 4 * x + 6;
                end
            end
        endfunction

        function void check_step(pixel_step_t got);
            pixel_step_t want;
            if (pending_steps.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
                return;
            end
            want = pending_steps.pop_front();
            for (int k = 0; k < 8; k++)
            begin
                if (got.addr[k] !== want.addr[k])
                begin
                    $error("%s expected %0d actual %0d", lane_names[k], want.addr[k],
                           got.addr[k]);
                    errors++;
                end
            end
            if (got.mask !== want.mask)
            begin
                $error("inside_mask expected %b actual %b", want.mask, got.mask);
                errors++;
            end
            if (got.col !== want.col)
            begin
                $error("pixel_color expected %0d actual %0d", want.col, got.col);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last_step expected %0d actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [10:0]        canvas_size = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [11:0] center_x = '0;
    logic signed [11:0] center_y = '0;
    logic [5:0]         radius = '0;
    logic [7:0]         color = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [19:0]        addr_px_py;
    logic [19:0]        addr_nx_py;
    logic [19:0]        addr_px_ny;
    logic [19:0]        addr_nx_ny;
    logic [19:0]        addr_py_px;
    logic [19:0]        addr_ny_px;
    logic [19:0]        addr_py_nx;
    logic [19:0]        addr_ny_nx;
    logic [7:0]         inside_mask;
    logic [7:0]         pixel_color;
    logic               last_step;

    circle_scoreboard board;
    int               burst_left = 0;
    int               stall_left = 0;
    int               idle_cycles = 0;

    midpoint_circle_raster dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .canvas_size (canvas_size),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .center_x    (center_x),
        .center_y    (center_y),
        .radius      (radius),
        .color       (color),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .addr_px_py  (addr_px_py),
        .addr_nx_py  (addr_nx_py),
        .addr_px_ny  (addr_px_ny),
        .addr_nx_ny  (addr_nx_ny),
        .addr_py_px  (addr_py_px),
        .addr_ny_px  (addr_ny_px),
        .addr_py_nx  (addr_py_nx),
        .addr_ny_nx  (addr_ny_nx),
        .inside_mask (inside_mask),
        .pixel_color (pixel_color),
        .last_step   (last_step)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result-side backpressure: random runs of stall and flow, flow runs longer.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(1, 12);
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = $urandom_range(1, 40);
            end
        end
        else
        begin
            stall_left--;
        end
    end

    always @(posedge clk)
    begin
        pixel_step_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.addr[0] = addr_px_py;
            got.addr[1] = addr_nx_py;
            got.addr[2] = addr_px_ny;
            got.addr[3] = addr_nx_ny;
            got.addr[4] = addr_py_px;
            got.addr[5] = addr_ny_px;
            got.addr[6] = addr_py_nx;
            got.addr[7] = addr_ny_nx;
            got.mask = inside_mask;
            got.col = pixel_color;
            got.last = last_step;
            board.check_step(got);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic hold_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_circle(circle_t c);
        center_x <= c.cx;
        center_y <= c.cy;
        radius <= c.r;
        color <= c.col;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        board.note_circle(c);
    endtask

    task automatic feed(circle_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap != 0)
                hold_sender(gap);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        send_circle(c);
    endtask

    task automatic wait_drained();
        while (board.pending_steps.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_canvas(logic [10:0] v);
        hold_sender(1);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        canvas_size <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_canvas(v);
    endtask

    // Centers mostly straddle the visible canvas so clipping happens on every edge.
    function automatic circle_t pick_circle();
        circle_t c;
        int      size;
        size = board.visible_size();
        if ($urandom_range(0, 9) < 7)
        begin
            c.cx = 12'(int'($urandom_range(0, size + 140)) - 70);
            c.cy = 12'(int'($urandom_range(0, size + 140)) - 70);
        end
        else
        begin
            c.cx = 12'($urandom);
            c.cy = 12'($urandom);
        end
        case ($urandom_range(0, 9))
            0: c.r = 6'd0;
            1: c.r = 6'd63;
            default: c.r = 6'($urandom_range(0, 63));
        endcase
        c.col = 8'($urandom);
        return c;
    endfunction

    initial
    begin
        logic [10:0] canvas_plan[8];
        circle_t     directed[16];
        board = new();
        canvas_plan = '{11'd1, 11'd1024, 11'd0, 11'd2047, 11'd16, 11'd37, 11'd0, 11'd800};
        canvas_plan[6] = 11'($urandom_range(2, 1023));
        directed = '{
            '{12'sd400, 12'sd400, 6'd0, 8'd0},
            '{12'sd400, 12'sd400, 6'd63, 8'd255},
            '{12'sd400, 12'sd400, 6'd1, 8'hA5},
            '{12'sd0, 12'sd0, 6'd10, 8'd1},
            '{12'sd799, 12'sd799, 6'd20, 8'd2},
            '{12'sd0, 12'sd799, 6'd63, 8'd3},
            '{12'sd799, 12'sd0, 6'd5, 8'd4},
            '{-12'sd2048, -12'sd2048, 6'd63, 8'd5},
            '{12'sd2047, 12'sd2047, 6'd63, 8'd6},
            '{-12'sd1, -12'sd1, 6'd1, 8'd7},
            '{12'sd800, 12'sd400, 6'd2, 8'd8},
            '{-12'sd63, 12'sd400, 6'd63, 8'd9},
            '{12'sd2047, -12'sd2048, 6'd0, 8'd10},
            '{12'sd100, 12'sd700, 6'd62, 8'd11},
            '{12'sd400, 12'sd400, 6'd50, 8'h5A},
            '{-12'sd1024, 12'sd2047, 6'd33, 8'hFF}
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            feed(directed[i]);

        foreach (canvas_plan[p])
        begin
            write_canvas(canvas_plan[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    hold_sender(1);
                    wait_drained();
                end
                feed(pick_circle());
            end
        end

        hold_sender(1);
        wait_drained();
        repeat (20) @(posedge clk);
        if (board.pending_steps.size() != 0)
        begin
            $error("%0d expected results never arrived", board.pending_steps.size());
            board.errors++;
        end
        if (board.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
